>>> hw/rtl/vfs_pkg.sv
package vfs_pkg;

    localparam int AXES             = 3;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANG_W            = 32;
    localparam int GUARD            = 8;
    localparam int CW               = 42;
    localparam int Z_W              = 26;
    localparam int MA_W             = 50;
    localparam int MB_W             = 18;
    localparam int P_W              = MA_W + MB_W;
    localparam int ATAN_IW          = 5;

    localparam logic signed [Z_W-1:0]  DEG90       = 26'sd5898240;
    localparam logic signed [Z_W-1:0]  DEG180      = 26'sd11796480;
    localparam logic signed [Z_W-1:0]  INC_MUL     = 26'sd17592186;
    localparam logic signed [MB_W-1:0] CORDIC_COMP = 18'sd39797;
    localparam logic signed [MB_W-1:0] RECIP25     = 18'sd83886;

    localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);

    typedef enum logic {
        OP_STEP      = 1'b0,
        OP_PIROUETTE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_MAX_ANGLE   = 3'd0,
        REG_SUPPRESS    = 3'd1,
        REG_DECAY       = 3'd2,
        REG_ROLL_GAINS  = 3'd3,
        REG_PITCH_GAINS = 3'd4,
        REG_YAW_GAINS   = 3'd5
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_INC1, S_INC2, S_INC3, S_DEC, S_DECR,
        S_RED1, S_RED2, S_RED3, S_RED4, S_RED5, S_RED6,
        S_KIA, S_KIAR, S_KPR, S_KPRR, S_FB, S_FBR, S_CMD, S_CMDR, S_OUT,
        S_CSTART, S_CWAIT, S_CX, S_CXR, S_CY, S_CYR
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [Z_W-1:0]   z;
    } t_cordic_req;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [ATAN_IW-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    // round to nearest, halves away from zero
    function automatic logic signed [P_W-1:0] rnd_sh(input logic signed [P_W-1:0] v,
                                                     input logic [5:0] sh);
        logic [P_W-1:0]        h;
        logic signed [P_W-1:0] t;
        h = {{(P_W-1){1'b0}}, 1'b1} << (sh - 6'd1);
        t = v + $signed(h) - $signed({{(P_W-1){1'b0}}, v[P_W-1]});
        return t >>> sh;
    endfunction

endpackage

>>> hw/rtl/virtual_flybar_stabilizer_unit.sv
// Virtual flybar stabilizer. Each input transaction is either a flybar step for one axis
// (op 0), which updates that axis's leaky integrated angle and returns one drive transaction,
// or a pirouette correction (op 1), which rotates the roll and pitch angles by yaw rate times
// dt and returns nothing. A step on axis 3 is dropped at once with no result. All multiplies
// run through one shared 50 x 18 signed multiplier with a registered product, stepped by a
// small sequencer, so the input side is ready only while the sequencer is idle. A step runs
// nine multiplies with their rounding stages before its result is offered; a pirouette runs
// the CORDIC, doing one iteration per cycle, followed by two gain-correction multiplies.
// Configuration writes are always accepted and should be issued only while the block is idle.
module virtual_flybar_stabilizer_unit #(
    parameter int CORDIC_STEPS = vfs_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // rate[15:0], stick[31:16], dt_us[47:32], restart[48]
    input  logic [2:0]  s_axis_tuser,   // op[0], axis[2:1]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // drive[23:0]
    output logic [1:0]  m_axis_tuser,   // axis_out[1:0]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [47:0] i_cfg_data
);
    import vfs_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [23:0] r_max_angle;
    logic [6:0]  r_pct;
    logic [15:0] r_decay;
    logic [47:0] r_gains [AXES];

    // per-axis flybar angle state
    logic signed [ANG_W-1:0] r_angle [AXES];

    // latched transaction fields
    logic               r_op;
    logic signed [15:0] r_rate;
    logic signed [15:0] r_stick;
    logic [15:0]        r_dt;
    logic               r_restart;
    logic [1:0]         r_axis;
    logic signed [15:0] r_kp;
    logic signed [15:0] r_ki;
    logic signed [15:0] r_sens;

    // datapath
    logic signed [P_W-1:0]   r_prod;
    logic signed [Z_W-1:0]   r_inc;
    logic signed [ANG_W-1:0] r_a;
    logic [22:0]             r_v;
    logic [17:0]             r_q;
    logic [16:0]             r_g;
    logic signed [47:0]      r_s;
    logic signed [35:0]      r_fb;
    logic signed [19:0]      r_cmd;

    // result register
    logic        r_out_valid;
    logic [23:0] r_out_drive;
    logic [1:0]  r_out_axis;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;

    logic               in_acc;
    logic               in_drop;
    logic [16:0]        stick_s17;
    logic [16:0]        stick_mag;
    logic signed [33:0] dec_sum;
    logic signed [33:0] dec_lim;
    logic signed [ANG_W-1:0] dec_a;
    logic [22:0]        q25;
    logic signed [47:0] kpr_term;
    logic signed [36:0] diff;
    logic [23:0]        drive_sat;
    logic               out_load;
    logic signed [P_W-1:0] crd_rnd;
    logic signed [ANG_W-1:0] crd_sat;

    t_cordic_req        crd_req;
    logic               crd_done;
    logic signed [CW-1:0] crd_x;
    logic signed [CW-1:0] crd_y;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    // a step on an axis past the last one is dropped without a result
    assign in_drop = (s_axis_tuser[0] == OP_STEP) && (s_axis_tuser[2:1] > AXIS_LAST);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // ---------------------------------------------------------------- cordic
    assign crd_req.start = (r_state == S_CSTART);
    assign crd_req.x     = r_angle[1];
    assign crd_req.y     = r_angle[0];
    assign crd_req.z     = r_inc;

    vfs_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (crd_req),
        .o_done  (crd_done),
        .o_x     (crd_x),
        .o_y     (crd_y)
    );

    // ---------------------------------------------------------------- helpers
    always_comb begin
        // stick magnitude, full scale negative taken as 32768
        stick_s17 = {r_stick[15], r_stick};
        stick_mag = stick_s17[16] ? (~stick_s17 + 17'd1) : stick_s17;

        // decay plus increment, clamped to plus or minus max angle
        dec_sum = 34'(rnd_sh(r_prod, 6'd16)) + 34'(r_inc);
        dec_lim = $signed({10'd0, r_max_angle});
        if (dec_sum > dec_lim) begin
            dec_a = ANG_W'(dec_lim);
        end else if (dec_sum < -dec_lim) begin
            dec_a = ANG_W'(-dec_lim);
        end else begin
            dec_a = ANG_W'(dec_sum);
        end

        // 25 * q by shift and add for the quotient correction
        q25 = {r_q[18-1:0], 4'd0} + {1'b0, r_q, 3'd0} + {4'd0, r_q}
            ;

        kpr_term = 48'($signed(r_prod[31:0])) <<< 12;

        diff = 37'(r_cmd) - 37'(r_fb);
        if (diff > 37'sd8388607) begin
            drive_sat = 24'h7FFFFF;
        end else if (diff < -37'sd8388608) begin
            drive_sat = 24'h800000;
        end else begin
            drive_sat = diff[23:0];
        end

        // gain-corrected cordic output, saturated to 32 bits signed
        crd_rnd = rnd_sh(r_prod, 6'(16 + GUARD));
        if (crd_rnd[P_W-1] && !(&crd_rnd[P_W-2:ANG_W-1])) begin
            crd_sat = {1'b1, {(ANG_W-1){1'b0}}};
        end else if (!crd_rnd[P_W-1] && (|crd_rnd[P_W-2:ANG_W-1])) begin
            crd_sat = {1'b0, {(ANG_W-1){1'b1}}};
        end else begin
            crd_sat = crd_rnd[ANG_W-1:0];
        end
    end

    // ---------------------------------------------------------------- shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_INC1: begin
                mul_a = MA_W'(INC_MUL);
                mul_b = MB_W'(r_rate);
            end
            S_INC2: begin
                mul_a = MA_W'($signed(r_prod[40:0]));
                mul_b = $signed({2'b00, r_dt});
            end
            S_DEC: begin
                mul_a = r_restart ? '0 : MA_W'(r_angle[r_axis]);
                mul_b = $signed({2'b00, r_decay});
            end
            S_RED1: begin
                mul_a = $signed({{(MA_W-17){1'b0}}, stick_mag});
                mul_b = $signed({11'd0, r_pct});
            end
            S_RED3: begin
                mul_a = $signed({{(MA_W-23){1'b0}}, r_v});
                mul_b = RECIP25;
            end
            S_KIA: begin
                mul_a = MA_W'(r_a);
                mul_b = MB_W'(r_ki);
            end
            S_KPR: begin
                mul_a = MA_W'(r_rate);
                mul_b = MB_W'(r_kp);
            end
            S_FB: begin
                mul_a = MA_W'(r_s);
                mul_b = $signed({1'b0, r_g});
            end
            S_CMD: begin
                mul_a = MA_W'(r_stick);
                mul_b = MB_W'(r_sens);
            end
            S_CX: begin
                mul_a = MA_W'(crd_x);
                mul_b = CORDIC_COMP;
            end
            S_CY: begin
                mul_a = MA_W'(crd_y);
                mul_b = CORDIC_COMP;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    assign out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc && !in_drop) n_state = S_INC1;
            S_INC1:   n_state = S_INC2;
            S_INC2:   n_state = S_INC3;
            S_INC3:   n_state = (r_op == OP_PIROUETTE) ? S_CSTART : S_DEC;
            S_DEC:    n_state = S_DECR;
            S_DECR:   n_state = S_RED1;
            S_RED1:   n_state = S_RED2;
            S_RED2:   n_state = S_RED3;
            S_RED3:   n_state = S_RED4;
            S_RED4:   n_state = S_RED5;
            S_RED5:   n_state = S_RED6;
            S_RED6:   n_state = S_KIA;
            S_KIA:    n_state = S_KIAR;
            S_KIAR:   n_state = S_KPR;
            S_KPR:    n_state = S_KPRR;
            S_KPRR:   n_state = S_FB;
            S_FB:     n_state = S_FBR;
            S_FBR:    n_state = S_CMD;
            S_CMD:    n_state = S_CMDR;
            S_CMDR:   n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            S_CSTART: n_state = S_CWAIT;
            S_CWAIT:  if (crd_done) n_state = S_CX;
            S_CX:     n_state = S_CXR;
            S_CXR:    n_state = S_CY;
            S_CY:     n_state = S_CYR;
            S_CYR:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_angle <= 24'd655360;
            r_pct       <= 7'd0;
            r_decay     <= 16'd64946;
            for (int i = 0; i < AXES; i++) begin
                r_gains[i] <= '0;
                r_angle[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    REG_MAX_ANGLE:   r_max_angle <= i_cfg_data[23:0];
                    REG_SUPPRESS:    r_pct       <= i_cfg_data[6:0];
                    REG_DECAY:       r_decay     <= i_cfg_data[15:0];
                    REG_ROLL_GAINS:  r_gains[0]  <= i_cfg_data;
                    REG_PITCH_GAINS: r_gains[1]  <= i_cfg_data;
                    REG_YAW_GAINS:   r_gains[2]  <= i_cfg_data;
                    default: ;
                endcase
            end

            // flybar angle updates
            if (r_state == S_DECR) r_angle[r_axis] <= dec_a;
            if (r_state == S_CXR)  r_angle[1]      <= crd_sat;
            if (r_state == S_CYR)  r_angle[0]      <= crd_sat;

            // result transaction register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (in_acc) begin
            r_op      <= s_axis_tuser[0];
            r_axis    <= s_axis_tuser[2:1];
            r_rate    <= $signed(s_axis_tdata[15:0]);
            r_stick   <= $signed(s_axis_tdata[31:16]);
            r_dt      <= s_axis_tdata[47:32];
            r_restart <= s_axis_tdata[48];
        end

        case (r_state)
            S_INC3: r_inc <= Z_W'(rnd_sh(r_prod, 6'd32));
            S_DEC: begin
                r_kp   <= $signed(r_gains[r_axis][15:0]);
                r_ki   <= $signed(r_gains[r_axis][31:16]);
                r_sens <= $signed(r_gains[r_axis][47:32]);
            end
            S_DECR: r_a <= dec_a;
            S_RED2: r_v <= r_prod[22:0] + 23'd12;
            S_RED4: r_q <= r_prod[38:21];
            S_RED5: if (r_v >= q25 + 23'd25) r_q <= r_q + 18'd1;
            S_RED6: r_g <= r_q[17:16] != 2'b00 ? 17'd0 : 17'd65536 - {1'b0, r_q[15:0]};
            S_KIAR: r_s <= r_prod[47:0];
            S_KPRR: r_s <= r_s + kpr_term;
            S_FBR:  r_fb  <= 36'(rnd_sh(r_prod, 6'd30));
            S_CMDR: r_cmd <= 20'(rnd_sh(r_prod, 6'd12));
            default: ;
        endcase

        if (out_load) begin
            r_out_drive <= drive_sat;
            r_out_axis  <= r_axis;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_drive;
    assign m_axis_tuser  = r_out_axis;

`ifndef SYNTH
    // an accepted item keeps the input side closed while the sequencer works
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !in_drop) |=> !s_axis_tready)
        else $error("input accepted while sequencer busy");

    // the clamped angle of a step stays within the configured limit
    a_angle_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECR) |=> ((r_angle[r_axis] <= $signed({8'd0, r_max_angle}))
                                 && (r_angle[r_axis] >= -$signed({8'd0, r_max_angle}))))
        else $error("flybar angle outside clamp");

    // the cordic only finishes while a pirouette waits for it
    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crd_done |-> (r_state == S_CWAIT))
        else $error("cordic done outside pirouette");

    // the corrected quotient of the suppress division is exact
    a_div25: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED6) |-> (({6'd0, r_q} * 24'd25 <= {1'b0, r_v})
                                 && ({1'b0, r_v} < {6'd0, r_q} * 24'd25 + 24'd25)))
        else $error("suppress quotient off by one");
`endif

endmodule

>>> hw/rtl/vfs_cordic.sv
module vfs_cordic #(
    parameter int STEPS = vfs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vfs_pkg::t_cordic_req            i_req,
    output logic                            o_done,
    output logic signed [vfs_pkg::CW-1:0]   o_x,
    output logic signed [vfs_pkg::CW-1:0]   o_y
);
    import vfs_pkg::*;

    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [CW-1:0]  r_x;
    logic signed [CW-1:0]  r_y;
    logic signed [Z_W-1:0] r_z;

    logic signed [CW-1:0]  ld_x;
    logic signed [CW-1:0]  ld_y;
    logic signed [Z_W-1:0] ld_z;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic signed [Z_W-1:0] at;

    // fold angles beyond a quarter turn by negating the vector
    always_comb begin
        ld_x = CW'(i_req.x) <<< GUARD;
        ld_y = CW'(i_req.y) <<< GUARD;
        ld_z = i_req.z;
        if (i_req.z > DEG90) begin
            ld_x = -ld_x;
            ld_y = -ld_y;
            ld_z = i_req.z - DEG180;
        end else if (i_req.z < -DEG90) begin
            ld_x = -ld_x;
            ld_y = -ld_y;
            ld_z = i_req.z + DEG180;
        end
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        at = atan_lut(ATAN_IW'(r_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= ld_x;
            r_y <= ld_y;
            r_z <= ld_z;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

>>> verif/tb_virtual_flybar_stabilizer_unit.sv
module tb_virtual_flybar_stabilizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import vfs_pkg::*;

    // flybar predictor and store of pending drive transactions
    class flybar_scoreboard;
        logic [23:0] lim_angle;
        logic [6:0]  suppress_pct;
        logic [15:0] decay_q16;
        logic [47:0] axis_gains [3];
        longint      angle [3];
        logic [23:0] drive_q [$];
        logic [1:0]  axis_q [$];
        int          mismatches;
        longint      arctan [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                     58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                     229, 115};

        function new();
            lim_angle    = 24'd655360;
            suppress_pct = '0;
            decay_q16    = 16'd64946;
            mismatches   = 0;
            for (int i = 0; i < 3; i++) begin
                axis_gains[i] = '0;
                angle[i]      = 0;
            end
        endfunction

        // round to nearest, halves away from zero
        function longint round_shift(longint v, int sh);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
            return (v < 0) ? -mag : mag;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_reg(t_reg idx, logic [47:0] value);
            case (idx)
                REG_MAX_ANGLE:   lim_angle    = value[23:0];
                REG_SUPPRESS:    suppress_pct = value[6:0];
                REG_DECAY:       decay_q16    = value[15:0];
                REG_ROLL_GAINS:  axis_gains[0] = value;
                REG_PITCH_GAINS: axis_gains[1] = value;
                REG_YAW_GAINS:   axis_gains[2] = value;
                default: ;
            endcase
        endfunction

        // rotate the (pitch, roll) pair by theta
        function void rotate(longint theta);
            longint x, y, z, dx, dy;
            x = angle[1] * 256;
            y = angle[0] * 256;
            z = theta;
            if (z > longint'(DEG90)) begin
                x = -x; y = -y; z = z - longint'(DEG180);
            end else if (z < -longint'(DEG90)) begin
                x = -x; y = -y; z = z + longint'(DEG180);
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - arctan[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + arctan[i];
                end
            end
            angle[1] = clip(round_shift(x * 39797, 24), -(longint'(1) <<< 31),
                            (longint'(1) <<< 31) - 1);
            angle[0] = clip(round_shift(y * 39797, 24), -(longint'(1) <<< 31),
                            (longint'(1) <<< 31) - 1);
        endfunction

        function void note_input(t_op op, logic signed [15:0] rate,
                                 logic signed [15:0] stick, logic [15:0] dt,
                                 logic restart, logic [1:0] ax);
            longint inc, a, lim, mag, g, kp, ki, sens, s, cmd, fb, drv;
            inc = round_shift(longint'(rate) * longint'(dt) * 17592186, 32);
            if (op == OP_PIROUETTE) begin
                rotate(inc);
                return;
            end
            if (ax > AXIS_LAST) return;
            if (restart) angle[ax] = 0;
            a   = round_shift(angle[ax] * longint'(decay_q16), 16) + inc;
            lim = longint'(lim_angle);
            a   = clip(a, -lim, lim);
            angle[ax] = a;
            mag = (stick < 0) ? -longint'(stick) : longint'(stick);
            g   = 65536 - (mag * longint'(suppress_pct) + 12) / 25;
            if (g < 0) g = 0;
            kp   = longint'($signed(axis_gains[ax][15:0]));
            ki   = longint'($signed(axis_gains[ax][31:16]));
            sens = longint'($signed(axis_gains[ax][47:32]));
            s    = ki * a + kp * longint'(rate) * 4096;
            cmd  = round_shift(longint'(stick) * sens, 12);
            fb   = round_shift(s * g, 30);
            drv  = clip(cmd - fb, -8388608, 8388607);
            drive_q.push_back(drv[23:0]);
            axis_q.push_back(ax);
        endfunction

        function void check_result(logic [23:0] drv, logic [1:0] ax);
            logic [23:0] e_drv;
            logic [1:0]  e_ax;
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive transaction: drive=%0d axis=%0d",
                             $signed(drv), ax);
                return;
            end
            e_drv = drive_q.pop_front();
            e_ax  = axis_q.pop_front();
            if (e_drv !== drv || e_ax !== ax) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("drive mismatch: expected drive=%0d axis=%0d, got drive=%0d axis=%0d",
                             $signed(e_drv), e_ax, $signed(drv), ax);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // rate, stick, dt_us, restart
    logic [2:0]  s_axis_tuser = '0;   // op, axis
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // drive
    logic [1:0]  m_axis_tuser;        // axis_out
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr = '0;
    logic [47:0] i_cfg_data = '0;

    flybar_scoreboard sb = new();

    // receiver hold-off request, counted down by the receiver process
    int hold_req = 0;

    virtual_flybar_stabilizer_unit uut (.*);

    always #2 i_clk = ~i_clk;

    // receiver: long hold-off on request, otherwise a pattern that changes mode
    int rx_cycle = 0;
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_req > 0 && hold_cnt == 0) begin
            hold_cnt <= hold_req;
            hold_req = 0;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_cycle % 5 != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    task automatic write_reg(t_reg idx, logic [47:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one input transaction, valid left high for the caller to keep or drop
    task automatic send_item(t_op op, logic signed [15:0] rate, logic signed [15:0] stick,
                             logic [15:0] dt, logic restart, logic [1:0] ax);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart, dt, stick, rate};
        s_axis_tuser  <= {ax, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, rate, stick, dt, restart, ax);
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait until every drive has come back, then let a pirouette finish
    task automatic drain();
        pause_sender(1);
        while (sb.drive_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_gains();
        write_reg(REG_ROLL_GAINS,  {$urandom, $urandom});
        write_reg(REG_PITCH_GAINS, {$urandom, $urandom});
        write_reg(REG_YAW_GAINS,   {$urandom, $urandom});
    endtask

    // well-formed steps with random content, some pirouettes and stray axis 3
    task automatic random_items(int n, bool_hold);
        int burst;
        logic signed [15:0] rate, stick;
        logic [15:0] dt;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
            rate  = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 16'sh7fff
                                                                             : 16'sh8000)
                                                : 16'($urandom);
            stick = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 32768) - 16384);
            dt    = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            if (bool_hold != 0 && k == n / 2)
                hold_req = 300;
            if (bool_hold != 0 && k == n / 4)
                drain();
            send_item(($urandom_range(0, 4) == 0) ? OP_PIROUETTE : OP_STEP, rate, stick, dt,
                      ($urandom_range(0, 7) == 0),
                      ($urandom_range(0, 29) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                pause_sender($urandom_range(0, 1) != 0 ? $urandom_range(1, 30) : 0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme settings and fields
        write_reg(REG_MAX_ANGLE, 48'd11796480);
        write_reg(REG_SUPPRESS, 48'd100);
        write_reg(REG_DECAY, 48'd65535);
        write_reg(REG_ROLL_GAINS,  {16'sh7fff, 16'sh7fff, 16'sh7fff});
        write_reg(REG_PITCH_GAINS, {16'sh8000, 16'sh8000, 16'sh8000});
        write_reg(REG_YAW_GAINS,   {16'sh1000, 16'shf000, 16'sh0800});
        write_reg(t_reg'(3'd7), 48'hffff_ffff_ffff);   // unknown index, ignored
        send_item(OP_STEP, 16'sh7fff, 16'sd16384, 16'hffff, 1'b1, 2'd0);
        send_item(OP_STEP, 16'sh8000, -16'sd16384, 16'hffff, 1'b1, 2'd1);
        send_item(OP_STEP, 16'sh7fff, 16'sh8000, 16'hffff, 1'b1, 2'd2);
        send_item(OP_STEP, 16'sh8000, 16'sh8000, 16'd0, 1'b0, 2'd0);
        send_item(OP_STEP, 16'sd0, 16'sd0, 16'd0, 1'b0, 2'd1);
        send_item(OP_STEP, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b0, 2'd3);
        send_item(OP_PIROUETTE, 16'sh7fff, 16'sh8000, 16'hffff, 1'b1, 2'd3);
        send_item(OP_PIROUETTE, 16'sh8000, 16'sd0, 16'hffff, 1'b0, 2'd0);
        send_item(OP_PIROUETTE, 16'sd1000, 16'sd0, 16'd5000, 1'b0, 2'd0);
        send_item(OP_STEP, 16'sd100, 16'sd8000, 16'd1000, 1'b0, 2'd0);
        send_item(OP_STEP, -16'sd100, -16'sd8000, 16'd1000, 1'b0, 2'd1);
        send_item(OP_STEP, 16'sd1, 16'sd1, 16'd1, 1'b0, 2'd2);
        drain();

        // suppress off, no decay, zero clamp
        write_reg(REG_SUPPRESS, 48'd0);
        write_reg(REG_DECAY, 48'd0);
        write_reg(REG_MAX_ANGLE, 48'd0);
        send_item(OP_STEP, 16'sh7fff, 16'sd16384, 16'hffff, 1'b0, 2'd0);
        send_item(OP_STEP, 16'sh8000, -16'sd12345, 16'd300, 1'b0, 2'd2);
        send_item(OP_PIROUETTE, 16'sd5000, 16'sd0, 16'd1000, 1'b0, 2'd1);
        drain();

        // random phases with varied settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_MAX_ANGLE, (ph == 0) ? 48'd11796480 : 48'($urandom_range(0, 11796480)));
            write_reg(REG_SUPPRESS, (ph == 1) ? 48'd0 : 48'($urandom_range(0, 100)));
            write_reg(REG_DECAY, (ph == 2) ? 48'd65535 : 48'($urandom_range(0, 65535)));
            random_gains();
            random_items(120, (ph == 1) ? 1 : 0);
            drain();
        end

        if (sb.mismatches == 0 && sb.drive_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/vfs_pkg.sv
hw/rtl/vfs_cordic.sv
hw/rtl/virtual_flybar_stabilizer_unit.sv
verif/tb_virtual_flybar_stabilizer_unit.sv
